FILE: rtl/core/hierarchical_timer_wheel_core_assert.svh
// assertion macros for the timer wheel core
// expects clk and rst in the scope of use
`ifndef HIERARCHICAL_TIMER_WHEEL_CORE_ASSERT_SVH
`define HIERARCHICAL_TIMER_WHEEL_CORE_ASSERT_SVH

// same-cycle implication
`define HTW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HTW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/htw_pkg.sv
// shared constants and types for the timer wheel core
// no dependencies
package htw_pkg;

  localparam int SLOTS_DEFAULT = 30;
  localparam int POOL_DEFAULT  = 64;
  localparam int LEVELS        = 4;
  localparam int LEVEL_W       = 2;
  localparam int LVL_CODE_W    = 3;
  localparam int DELAY_W       = 20;
  localparam int TAG_W         = 16;
  localparam int HANDLE_W      = 6;
  localparam int LINK_W        = 7;
  localparam int KIND_W        = 3;
  localparam int REQ_W         = 2;

  localparam logic [LINK_W-1:0] LINK_NIL = '1;

  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CANCEL = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK   = 2'd2;

  localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REJECTED  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CANCELLED = 3'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EXPIRED   = 3'd4;

  // per-field write enables of the entry memory
  typedef struct packed {
    logic nxt;
    logic prv;
    logic slt;
    logic rem;
    logic tag;
  } ent_we_t;

endpackage

FILE: rtl/core/hierarchical_timer_wheel_core.sv
// four-level timer wheel core: sequencer over the slot and entry memories
// depends on htw_pkg, htw_entry_mem, htw_slot_mem, htw_div and the assert header
//
// Command port: a request is taken at a clock edge with start high and busy
// low. req_type selects add (delay_ticks, user_tag), cancel (cancel_handle)
// or one tick. Each result sits on result_kind, entry_handle, expired_tag and
// last_of_run for one cycle with done high; last_of_run marks the final
// result of a request. The receiver cannot stall, so results are never held.
// A rejected add or a cancel of an unused handle answers in the next cycle,
// unless the add is rejected at level select after the fold. A valid cancel
// answers after an entry read and two unlink writes. An add answers after
// fold, level select, the reciprocal divider, slot head read, link write and
// back-link fix. A tick advances level 0 and each level above a wrapped one;
// each entry of a walked slot is unlinked, then expired or re-placed. The
// tick walk is the slow path: one entry at a time through the entry memory
// port. A tick with no expiry gives no result. busy drops with the last
// result, so one request runs at a time. Reset clears the wheel positions,
// the slot valid bits and the in-use flags at once.
module hierarchical_timer_wheel_core #(
  parameter int SLOTS_PER_WHEEL = htw_pkg::SLOTS_DEFAULT,
  parameter int POOL_DEPTH      = htw_pkg::POOL_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [htw_pkg::REQ_W-1:0]     req_type,
  input  logic [htw_pkg::DELAY_W-1:0]   delay_ticks,
  input  logic [htw_pkg::TAG_W-1:0]     user_tag,
  input  logic [htw_pkg::HANDLE_W-1:0]  cancel_handle,
  output logic                          done,
  output logic [htw_pkg::KIND_W-1:0]    result_kind,
  output logic [htw_pkg::HANDLE_W-1:0]  entry_handle,
  output logic [htw_pkg::TAG_W-1:0]     expired_tag,
  output logic                          last_of_run
);
  import htw_pkg::*;

  localparam int S          = SLOTS_PER_WHEEL;
  localparam int U1         = S;
  localparam int U2         = S * S;
  localparam int U3         = S * S * S;
  localparam int U4         = S * S * S * S;
  localparam int SLOT_COUNT = LEVELS * S;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int POS_W      = $clog2(S);
  localparam int REM_W      = $clog2(U3);
  localparam int D_W        = DELAY_W + 1;
  localparam int H_W        = $clog2(POOL_DEPTH);
  localparam int G_W        = $clog2(POOL_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_FOLD, ST_LEVEL, ST_DIV, ST_SLOT, ST_HEAD, ST_FIX,
    ST_ADV, ST_THEAD, ST_TENT, ST_UNL1, ST_UNL2, ST_TNEXT, ST_LVLEND, ST_FINISH
  } state_t;

  state_t state;

  logic [POS_W-1:0]      pos [LEVELS];
  logic [POOL_DEPTH-1:0] in_use;
  logic                  mode_add;
  logic                  mode_tick;
  logic [H_W-1:0]        h;
  logic [TAG_W-1:0]      tag_r;
  logic [D_W-1:0]        d;
  logic [LVL_CODE_W-1:0] lvl0;
  logic [LEVEL_W-1:0]    plvl;
  logic [LEVEL_W-1:0]    tl;
  logic [SLOT_W-1:0]     slot_idx;
  logic [LINK_W-1:0]     old_head;
  logic [LINK_W-1:0]     e_next;
  logic [LINK_W-1:0]     e_prev;
  logic [SLOT_W-1:0]     e_slot;
  logic [REM_W-1:0]      e_rem;
  logic [G_W-1:0]        guard;
  logic                  pend_v;
  logic [H_W-1:0]        pend_h;
  logic [TAG_W-1:0]      pend_tag;

  ent_we_t           ent_we;
  logic [H_W-1:0]    ent_waddr;
  logic [LINK_W-1:0] ent_wnext;
  logic [LINK_W-1:0] ent_wprev;
  logic [H_W-1:0]    ent_raddr;
  logic [LINK_W-1:0] ent_rnext;
  logic [LINK_W-1:0] ent_rprev;
  logic [SLOT_W-1:0] ent_rslot;
  logic [REM_W-1:0]  ent_rrem;
  logic [TAG_W-1:0]  ent_rtag;

  logic              slot_we;
  logic [SLOT_W-1:0] slot_waddr;
  logic [LINK_W-1:0] slot_wdata;
  logic [SLOT_W-1:0] slot_raddr;
  logic [LINK_W-1:0] slot_rdata;

  logic              div_start;
  logic              div_done;
  logic [POS_W-1:0]  div_quo;
  logic [D_W-1:0]    div_rem;

  logic [H_W-1:0]        free_h;
  logic                  free_any;
  logic [LVL_CODE_W-1:0] lvl_in;
  logic [LVL_CODE_W-1:0] lvl_d;
  logic [D_W-1:0]        fold;
  logic [POS_W:0]        psum;
  logic [POS_W-1:0]      pmod;
  logic [SLOT_W-1:0]     slot_calc;
  logic [POS_W-1:0]      pos_new;
  logic [SLOT_W-1:0]     adv_slot;
  logic                  cancel_ok;
  logic                  single_kind;

  function automatic logic [LVL_CODE_W-1:0] level_of(input logic [D_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w < 32'(U1))      level_of = 3'd0;
    else if (w < 32'(U2)) level_of = 3'd1;
    else if (w < 32'(U3)) level_of = 3'd2;
    else if (w < 32'(U4)) level_of = 3'd3;
    else                  level_of = 3'd4;
  endfunction

  function automatic logic link_ok(input logic [LINK_W-1:0] l);
    link_ok = 32'(l) < 32'(POOL_DEPTH);
  endfunction

  htw_entry_mem #(
    .POOL_DEPTH (POOL_DEPTH),
    .SLOT_W     (SLOT_W),
    .REM_W      (REM_W)
  ) u_entry_mem (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wnext (ent_wnext),
    .wprev (ent_wprev),
    .wslot (slot_idx),
    .wrem  (REM_W'(div_rem)),
    .wtag  (tag_r),
    .raddr (ent_raddr),
    .rnext (ent_rnext),
    .rprev (ent_rprev),
    .rslot (ent_rslot),
    .rrem  (ent_rrem),
    .rtag  (ent_rtag)
  );

  htw_slot_mem #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_slot_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  htw_div #(
    .D_W   (D_W),
    .Q_W   (POS_W),
    .SLOTS (S)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (d),
    .lvl   (lvl_d[LEVEL_W-1:0]),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // lowest free entry
  always_comb begin
    free_h   = '0;
    free_any = 1'b0;
    for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_h   = H_W'(i);
        free_any = 1'b1;
      end
    end
  end

  assign busy        = (state != ST_IDLE);
  assign lvl_in      = level_of(D_W'(delay_ticks));
  assign lvl_d       = level_of(d);
  assign cancel_ok   = (32'(cancel_handle) < 32'(POOL_DEPTH)) &&
                       in_use[cancel_handle[H_W-1:0]];
  assign single_kind = (result_kind != KIND_EXPIRED);

  always_comb begin
    fold = '0;
    if (lvl0 >= 3'd1) fold = fold + D_W'(pos[0]);
    if (lvl0 >= 3'd2) fold = fold + D_W'(32'(pos[1]) * U1);
    if (lvl0 >= 3'd3) fold = fold + D_W'(32'(pos[2]) * U2);
  end

  assign psum      = (POS_W+1)'(pos[plvl]) + (POS_W+1)'(div_quo);
  assign pmod      = (32'(psum) >= 32'(S)) ? POS_W'(32'(psum) - 32'(S)) : POS_W'(psum);
  assign slot_calc = SLOT_W'(32'(plvl) * S) + SLOT_W'(pmod);
  assign pos_new   = (32'(pos[tl]) == 32'(S - 1)) ? '0 : pos[tl] + 1'b1;
  assign adv_slot  = SLOT_W'(32'(tl) * S) + SLOT_W'(pos_new);

  // memory port control
  always_comb begin
    ent_we     = '0;
    ent_waddr  = h;
    ent_wnext  = old_head;
    ent_wprev  = LINK_NIL;
    ent_raddr  = e_next[H_W-1:0];
    slot_we    = 1'b0;
    slot_waddr = slot_idx;
    slot_wdata = LINK_W'(h);
    slot_raddr = slot_calc;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        ent_raddr = cancel_handle[H_W-1:0];
      end
      ST_LEVEL: begin
        div_start = (lvl_d < 3'(LEVELS));
      end
      ST_HEAD: begin
        ent_we     = '{nxt: 1'b1, prv: 1'b1, slt: 1'b1, rem: 1'b1, tag: mode_add};
        ent_wnext  = slot_rdata;
        slot_we    = 1'b1;
      end
      ST_FIX: begin
        ent_we.prv = link_ok(old_head);
        ent_waddr  = old_head[H_W-1:0];
        ent_wprev  = LINK_W'(h);
      end
      ST_ADV: begin
        slot_raddr = adv_slot;
      end
      ST_THEAD: begin
        ent_raddr = slot_rdata[H_W-1:0];
      end
      ST_UNL1: begin
        if (link_ok(e_prev)) begin
          ent_we.nxt = 1'b1;
          ent_waddr  = e_prev[H_W-1:0];
          ent_wnext  = e_next;
        end else begin
          slot_we    = 1'b1;
          slot_waddr = e_slot;
          slot_wdata = e_next;
        end
      end
      ST_UNL2: begin
        ent_we.prv = link_ok(e_next);
        ent_waddr  = e_next[H_W-1:0];
        ent_wprev  = e_prev;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_use    <= '0;
      done      <= 1'b0;
      pend_v    <= 1'b0;
      mode_add  <= 1'b0;
      mode_tick <= 1'b0;
      for (int i = 0; i < LEVELS; i++) pos[i] <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            case (req_type)
              REQ_ADD: begin
                if (!free_any || lvl_in >= 3'(LEVELS)) begin
                  done         <= 1'b1;
                  result_kind  <= KIND_REJECTED;
                  entry_handle <= '0;
                  expired_tag  <= '0;
                  last_of_run  <= 1'b1;
                end else begin
                  h         <= free_h;
                  tag_r     <= user_tag;
                  d         <= D_W'(delay_ticks);
                  lvl0      <= lvl_in;
                  mode_add  <= 1'b1;
                  mode_tick <= 1'b0;
                  state     <= ST_FOLD;
                end
              end
              REQ_CANCEL: begin
                if (cancel_ok) begin
                  h         <= cancel_handle[H_W-1:0];
                  mode_add  <= 1'b0;
                  mode_tick <= 1'b0;
                  state     <= ST_TENT;
                end else begin
                  done         <= 1'b1;
                  result_kind  <= KIND_UNUSED;
                  entry_handle <= cancel_handle;
                  expired_tag  <= '0;
                  last_of_run  <= 1'b1;
                end
              end
              REQ_TICK: begin
                tl        <= '0;
                pend_v    <= 1'b0;
                mode_add  <= 1'b0;
                mode_tick <= 1'b1;
                state     <= ST_ADV;
              end
              default: begin
              end
            endcase
          end
        end
        ST_FOLD: begin
          d     <= d + fold;
          state <= ST_LEVEL;
        end
        ST_LEVEL: begin
          if (lvl_d >= 3'(LEVELS)) begin
            done         <= 1'b1;
            result_kind  <= KIND_REJECTED;
            entry_handle <= '0;
            expired_tag  <= '0;
            last_of_run  <= 1'b1;
            state        <= ST_IDLE;
          end else begin
            plvl  <= lvl_d[LEVEL_W-1:0];
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) state <= ST_SLOT;
        end
        ST_SLOT: begin
          slot_idx <= slot_calc;
          state    <= ST_HEAD;
        end
        ST_HEAD: begin
          old_head <= slot_rdata;
          state    <= ST_FIX;
        end
        ST_FIX: begin
          if (mode_add) begin
            in_use[h]    <= 1'b1;
            done         <= 1'b1;
            result_kind  <= KIND_ADDED;
            entry_handle <= HANDLE_W'(h);
            expired_tag  <= tag_r;
            last_of_run  <= 1'b1;
            state        <= ST_IDLE;
          end else begin
            state <= ST_TNEXT;
          end
        end
        ST_ADV: begin
          pos[tl] <= pos_new;
          guard   <= '0;
          state   <= ST_THEAD;
        end
        ST_THEAD: begin
          if (link_ok(slot_rdata)) begin
            h     <= slot_rdata[H_W-1:0];
            state <= ST_TENT;
          end else begin
            state <= ST_LVLEND;
          end
        end
        ST_TENT: begin
          e_next <= ent_rnext;
          e_prev <= ent_rprev;
          e_slot <= ent_rslot;
          e_rem  <= ent_rrem;
          if (mode_tick) tag_r <= ent_rtag;
          guard  <= guard + 1'b1;
          state  <= ST_UNL1;
        end
        ST_UNL1: begin
          state <= ST_UNL2;
        end
        ST_UNL2: begin
          if (!mode_tick) begin
            in_use[h]    <= 1'b0;
            done         <= 1'b1;
            result_kind  <= KIND_CANCELLED;
            entry_handle <= HANDLE_W'(h);
            expired_tag  <= '0;
            last_of_run  <= 1'b1;
            state        <= ST_IDLE;
          end else if (e_rem != '0) begin
            d     <= D_W'(e_rem);
            state <= ST_LEVEL;
          end else begin
            in_use[h] <= 1'b0;
            if (pend_v) begin
              done         <= 1'b1;
              result_kind  <= KIND_EXPIRED;
              entry_handle <= HANDLE_W'(pend_h);
              expired_tag  <= pend_tag;
              last_of_run  <= 1'b0;
            end
            pend_v   <= 1'b1;
            pend_h   <= h;
            pend_tag <= tag_r;
            state    <= ST_TNEXT;
          end
        end
        ST_TNEXT: begin
          if (link_ok(e_next) && guard < G_W'(POOL_DEPTH)) begin
            h     <= e_next[H_W-1:0];
            state <= ST_TENT;
          end else begin
            state <= ST_LVLEND;
          end
        end
        ST_LVLEND: begin
          if (pos[tl] != '0 || tl == LEVEL_W'(LEVELS - 1)) begin
            state <= ST_FINISH;
          end else begin
            tl    <= tl + 1'b1;
            state <= ST_ADV;
          end
        end
        ST_FINISH: begin
          if (pend_v) begin
            done         <= 1'b1;
            result_kind  <= KIND_EXPIRED;
            entry_handle <= HANDLE_W'(pend_h);
            expired_tag  <= pend_tag;
            last_of_run  <= 1'b1;
          end
          pend_v <= 1'b0;
          state  <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`include "hierarchical_timer_wheel_core_assert.svh"

  `HTW_ASSERT_NEXT(a_busy_needs_start, !busy && !start, !busy, "busy rose without a request")
  `HTW_ASSERT_NOW(a_mid_run_busy, done && !last_of_run, busy, "non-final result after run ended")
  `HTW_ASSERT_NOW(a_single_last, done && single_kind, last_of_run, "single result not marked last")

endmodule

FILE: rtl/core/htw_entry_mem.sv
// timer entry memory: link, slot, remainder and tag fields per entry
// depends on htw_pkg
module htw_entry_mem #(
  parameter int POOL_DEPTH = htw_pkg::POOL_DEFAULT,
  parameter int SLOT_W     = 7,
  parameter int REM_W      = 15
) (
  input  logic                              clk,
  input  htw_pkg::ent_we_t                  we,
  input  logic [$clog2(POOL_DEPTH)-1:0]     waddr,
  input  logic [htw_pkg::LINK_W-1:0]        wnext,
  input  logic [htw_pkg::LINK_W-1:0]        wprev,
  input  logic [SLOT_W-1:0]                 wslot,
  input  logic [REM_W-1:0]                  wrem,
  input  logic [htw_pkg::TAG_W-1:0]         wtag,
  input  logic [$clog2(POOL_DEPTH)-1:0]     raddr,
  output logic [htw_pkg::LINK_W-1:0]        rnext,
  output logic [htw_pkg::LINK_W-1:0]        rprev,
  output logic [SLOT_W-1:0]                 rslot,
  output logic [REM_W-1:0]                  rrem,
  output logic [htw_pkg::TAG_W-1:0]         rtag
);
  import htw_pkg::*;

  logic [LINK_W-1:0] mem_next [POOL_DEPTH];
  logic [LINK_W-1:0] mem_prev [POOL_DEPTH];
  logic [SLOT_W-1:0] mem_slot [POOL_DEPTH];
  logic [REM_W-1:0]  mem_rem  [POOL_DEPTH];
  logic [TAG_W-1:0]  mem_tag  [POOL_DEPTH];

  always_ff @(posedge clk) begin
    if (we.nxt) mem_next[waddr] <= wnext;
    if (we.prv) mem_prev[waddr] <= wprev;
    if (we.slt) mem_slot[waddr] <= wslot;
    if (we.rem) mem_rem[waddr]  <= wrem;
    if (we.tag) mem_tag[waddr]  <= wtag;
    rnext <= mem_next[raddr];
    rprev <= mem_prev[raddr];
    rslot <= mem_slot[raddr];
    rrem  <= mem_rem[raddr];
    rtag  <= mem_tag[raddr];
  end

endmodule

FILE: rtl/core/htw_slot_mem.sv
// slot head memory with per-slot valid bits, unwritten slots read empty
// depends on htw_pkg
module htw_slot_mem #(
  parameter int SLOT_COUNT = 120
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              we,
  input  logic [$clog2(SLOT_COUNT)-1:0]     waddr,
  input  logic [htw_pkg::LINK_W-1:0]        wdata,
  input  logic [$clog2(SLOT_COUNT)-1:0]     raddr,
  output logic [htw_pkg::LINK_W-1:0]        rdata
);
  import htw_pkg::*;

  logic [LINK_W-1:0]     mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] valid;
  logic [LINK_W-1:0]     mem_q;
  logic                  valid_q;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    mem_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (we) valid[waddr] <= 1'b1;
      valid_q <= valid[raddr];
    end
  end

  assign rdata = valid_q ? mem_q : LINK_NIL;

endmodule

FILE: rtl/core/htw_div.sv
// quotient and remainder by a wheel unit, reciprocal multiply with one correction step
// no dependencies beyond its parameters
module htw_div #(
  parameter int D_W   = 21,
  parameter int Q_W   = 5,
  parameter int SLOTS = 30
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [D_W-1:0] num,
  input  logic [1:0]     lvl,
  output logic           done,
  output logic [Q_W-1:0] quo,
  output logic [D_W-1:0] rem
);
  localparam int     M_W = D_W + 1;
  localparam int     P_W = D_W + M_W;
  localparam longint U1  = longint'(SLOTS);
  localparam longint U2  = U1 * U1;
  localparam longint U3  = U2 * U1;
  localparam longint ONE = longint'(1) << D_W;
  localparam logic [M_W-1:0] M0 = M_W'(ONE);
  localparam logic [M_W-1:0] M1 = M_W'(ONE / U1);
  localparam logic [M_W-1:0] M2 = M_W'(ONE / U2);
  localparam logic [M_W-1:0] M3 = M_W'(ONE / U3);

  logic [1:0]     stg;
  logic [D_W-1:0] n_r;
  logic [D_W-1:0] u_r;
  logic [M_W-1:0] m_r;
  logic [Q_W-1:0] qe;
  logic [D_W-1:0] r0;
  logic [P_W-1:0] prod;
  logic [D_W-1:0] back;

  // estimate is the true quotient or one below it
  assign prod = P_W'(n_r) * P_W'(m_r);
  assign back = D_W'(D_W'(qe) * u_r);
  assign done = (stg == 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      stg <= 2'd0;
    end else if (start) begin
      stg <= 2'd1;
    end else if (stg != 2'd0) begin
      stg <= stg + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r <= num;
      case (lvl)
        2'd0: begin
          u_r <= D_W'(1);
          m_r <= M0;
        end
        2'd1: begin
          u_r <= D_W'(U1);
          m_r <= M1;
        end
        2'd2: begin
          u_r <= D_W'(U2);
          m_r <= M2;
        end
        default: begin
          u_r <= D_W'(U3);
          m_r <= M3;
        end
      endcase
    end else begin
      case (stg)
        2'd1: qe <= Q_W'(prod >> D_W);
        2'd2: r0 <= n_r - back;
        2'd3: begin
          if (r0 >= u_r) begin
            quo <= qe + 1'b1;
            rem <= r0 - u_r;
          end else begin
            quo <= qe;
            rem <= r0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
